/* hw/rtl/sorted_tree_record_parser_top_defines.svh */
// assertion macros for the sorted tree record parser
// expects clk and rst_n in the scope of each use
`ifndef SORTED_TREE_RECORD_PARSER_TOP_DEFINES_SVH
`define SORTED_TREE_RECORD_PARSER_TOP_DEFINES_SVH

// same-cycle implication
`define STP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define STP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/stp_pkg.sv */
// shared types, codes and helpers of the sorted tree record parser
// no dependencies
`default_nettype none

package stp_pkg;

  localparam int HASH_BYTES_DEF = 32;
  localparam int MAX_NAME_DEF   = 256;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_TYPE     = 3'd1,
    ST_TRUNC    = 3'd2,
    ST_CODE     = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_LONG     = 3'd5,
    ST_UNSORTED = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    ROLE_TYPE = 2'd0,
    ROLE_HASH = 2'd1,
    ROLE_LEN  = 2'd2,
    ROLE_NAME = 2'd3
  } role_t;

  typedef enum logic [0:0] {
    CFG_BLOB = 1'b0,
    CFG_TREE = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       payload_last;
  } in_item_t;

  typedef struct packed {
    logic [1:0] byte_role;
    logic [7:0] byte_value;
    logic       entry_end;
    logic [8:0] name_length;
    logic [2:0] parse_status;
    logic       payload_end;
  } out_item_t;

  typedef struct packed {
    logic [7:0] blob_type_code;
    logic [7:0] tree_type_code;
  } cfg_regs_t;

  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  function automatic logic [8:0] sat9(input logic [15:0] v);
    return (v > 16'd511) ? 9'd511 : v[8:0];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/stp_ram.sv */
// generic single-port-write, single-port-read ram with registered read
// uses stp_pkg for the address width helper
`default_nettype none

module stp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = stp_pkg::MAX_NAME_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               wr_en,
  input  wire logic [stp_pkg::addr_w(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                   wr_data,
  input  wire logic [stp_pkg::addr_w(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                   rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* hw/rtl/stp_parser.sv */
// field parser, length decoder and name order check, one beat per cycle while accept is high
// uses stp_pkg and the assertion macro header; drives the name ram ports
`default_nettype none
`include "sorted_tree_record_parser_top_defines.svh"

module stp_parser #(
  parameter int HASH_BYTES = stp_pkg::HASH_BYTES_DEF,
  parameter int MAX_NAME   = stp_pkg::MAX_NAME_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  accept,
  input  wire stp_pkg::in_item_t                     in_item,
  input  wire stp_pkg::cfg_regs_t                    cfg,
  input  wire logic [7:0]                            rd_data,
  output logic      [stp_pkg::addr_w(MAX_NAME)-1:0] rd_addr,
  output logic                                       wr_en,
  output logic      [stp_pkg::addr_w(MAX_NAME)-1:0] wr_addr,
  output logic      [7:0]                            wr_data,
  output stp_pkg::out_item_t                         result
);

  localparam int HW = $clog2(HASH_BYTES + 1);
  localparam int NW = $clog2(MAX_NAME + 1);
  localparam int AW = stp_pkg::addr_w(MAX_NAME);
  localparam logic [HW-1:0] HASH_LAST = HW'(HASH_BYTES);
  localparam logic [15:0]   MAX_LEN   = 16'(MAX_NAME);

  typedef enum logic [1:0] {
    PH_TYPE = 2'd0,
    PH_HASH = 2'd1,
    PH_LEN  = 2'd2,
    PH_NAME = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ORD_EQ   = 2'd0,
    ORD_LESS = 2'd1,
    ORD_MORE = 2'd2
  } ord_t;

  phase_t            phase_r, phase_nxt;
  logic [HW-1:0]     hash_cnt_r, hash_cnt_nxt;
  logic [15:0]       len_acc_r, len_acc_nxt;
  logic [3:0]        len_cnt_r, len_cnt_nxt;
  logic [NW-1:0]     name_idx_r, name_idx_nxt;
  logic [NW-1:0]     cur_len_r, cur_len_nxt;
  logic [NW-1:0]     prev_len_r, prev_len_nxt;
  logic              have_prev_r, have_prev_nxt;
  ord_t              order_r, order_nxt;
  stp_pkg::status_t  sticky_r, sticky_nxt;

  logic [7:0]        b;
  logic              last;
  logic [6:0]        grp;
  logic              more;
  logic [21:0]       shifted;
  logic [21:0]       acc_sum;
  logic [15:0]       acc_upd;
  logic [HW-1:0]     hash_inc;
  logic [NW-1:0]     idx_inc;
  ord_t              ord_cur;
  stp_pkg::role_t    role;
  stp_pkg::status_t  err;
  logic              end_flag;
  logic [8:0]        nlen;
  logic              name_wr;
  logic [NW-1:0]     idx_sel;

  assign b    = in_item.data_byte;
  assign last = in_item.payload_last;
  assign grp  = b[6:0];
  assign more = b[7];

  // leb128 accumulate with saturation at 16 bits
  always_comb begin
    unique case (len_cnt_r)
      4'd0:    shifted = {15'd0, grp};
      4'd1:    shifted = {8'd0, grp, 7'd0};
      4'd2:    shifted = {1'b0, grp, 14'd0};
      default: shifted = 22'd0;
    endcase
    acc_sum = {6'd0, len_acc_r} + shifted;
    if (len_cnt_r < 4'd3) begin
      acc_upd = (acc_sum > 22'h00FFFF) ? 16'hFFFF : acc_sum[15:0];
    end else begin
      acc_upd = (grp != 7'd0) ? 16'hFFFF : len_acc_r;
    end
  end

  assign hash_inc = hash_cnt_r + HW'(1);
  assign idx_inc  = name_idx_r + NW'(1);

  always_comb begin
    ord_cur = order_r;
    if (order_r == ORD_EQ && have_prev_r) begin
      if (name_idx_r >= prev_len_r) begin
        ord_cur = ORD_MORE;
      end else if (b < rd_data) begin
        ord_cur = ORD_LESS;
      end else if (b > rd_data) begin
        ord_cur = ORD_MORE;
      end
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    hash_cnt_nxt  = hash_cnt_r;
    len_acc_nxt   = len_acc_r;
    len_cnt_nxt   = len_cnt_r;
    name_idx_nxt  = name_idx_r;
    cur_len_nxt   = cur_len_r;
    prev_len_nxt  = prev_len_r;
    have_prev_nxt = have_prev_r;
    order_nxt     = order_r;
    sticky_nxt    = sticky_r;
    role          = stp_pkg::ROLE_TYPE;
    err           = stp_pkg::ST_OK;
    end_flag      = 1'b0;
    nlen          = 9'd0;
    name_wr       = 1'b0;

    if (sticky_r == stp_pkg::ST_OK) begin
      unique case (phase_r)
        PH_TYPE: begin
          role = stp_pkg::ROLE_TYPE;
          if (last) begin
            err = stp_pkg::ST_TRUNC;
          end else if (b != cfg.blob_type_code && b != cfg.tree_type_code) begin
            err = stp_pkg::ST_TYPE;
          end else begin
            hash_cnt_nxt = '0;
            len_acc_nxt  = 16'd0;
            len_cnt_nxt  = 4'd0;
            phase_nxt    = PH_HASH;
          end
        end
        PH_HASH: begin
          role         = stp_pkg::ROLE_HASH;
          hash_cnt_nxt = hash_inc;
          if (last) begin
            err = stp_pkg::ST_TRUNC;
          end else if (hash_inc >= HASH_LAST) begin
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          role = stp_pkg::ROLE_LEN;
          if (len_cnt_r == 4'd9 && (more || grp > 7'd1)) begin
            err = stp_pkg::ST_CODE;
          end else begin
            len_acc_nxt = acc_upd;
            len_cnt_nxt = len_cnt_r + 4'd1;
            if (more) begin
              if (last) begin
                err = stp_pkg::ST_TRUNC;
              end
            end else begin
              nlen = stp_pkg::sat9(acc_upd);
              if (acc_upd == 16'd0) begin
                err = stp_pkg::ST_EMPTY;
              end else if (acc_upd > MAX_LEN) begin
                err = stp_pkg::ST_LONG;
              end else if (last) begin
                err = stp_pkg::ST_TRUNC;
              end else begin
                cur_len_nxt  = acc_upd[NW-1:0];
                name_idx_nxt = '0;
                order_nxt    = ORD_EQ;
                phase_nxt    = PH_NAME;
              end
            end
          end
        end
        PH_NAME: begin
          role         = stp_pkg::ROLE_NAME;
          nlen         = stp_pkg::sat9(16'(cur_len_r));
          name_wr      = 1'b1;
          order_nxt    = ord_cur;
          name_idx_nxt = idx_inc;
          if (idx_inc >= cur_len_r) begin
            end_flag = 1'b1;
            if (have_prev_r && ord_cur != ORD_MORE &&
                (ord_cur == ORD_LESS || cur_len_r <= prev_len_r)) begin
              err = stp_pkg::ST_UNSORTED;
            end else begin
              prev_len_nxt  = cur_len_r;
              have_prev_nxt = 1'b1;
              phase_nxt     = PH_TYPE;
            end
          end else if (last) begin
            err = stp_pkg::ST_TRUNC;
          end
        end
        default: begin
          role = stp_pkg::ROLE_TYPE;
        end
      endcase
      sticky_nxt = err;
    end else begin
      err = sticky_r;
    end

    // end of payload returns the parse state to reset
    if (last) begin
      phase_nxt     = PH_TYPE;
      hash_cnt_nxt  = '0;
      len_acc_nxt   = 16'd0;
      len_cnt_nxt   = 4'd0;
      name_idx_nxt  = '0;
      cur_len_nxt   = '0;
      prev_len_nxt  = '0;
      have_prev_nxt = 1'b0;
      order_nxt     = ORD_EQ;
      sticky_nxt    = stp_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TYPE;
      hash_cnt_r  <= '0;
      len_acc_r   <= 16'd0;
      len_cnt_r   <= 4'd0;
      name_idx_r  <= '0;
      cur_len_r   <= '0;
      prev_len_r  <= '0;
      have_prev_r <= 1'b0;
      order_r     <= ORD_EQ;
      sticky_r    <= stp_pkg::ST_OK;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      hash_cnt_r  <= hash_cnt_nxt;
      len_acc_r   <= len_acc_nxt;
      len_cnt_r   <= len_cnt_nxt;
      name_idx_r  <= name_idx_nxt;
      cur_len_r   <= cur_len_nxt;
      prev_len_r  <= prev_len_nxt;
      have_prev_r <= have_prev_nxt;
      order_r     <= order_nxt;
      sticky_r    <= sticky_nxt;
    end
  end

  // prefetch the stored byte for the index the next beat will use
  assign idx_sel = accept ? name_idx_nxt : name_idx_r;
  assign rd_addr = idx_sel[AW-1:0];
  assign wr_en   = accept && name_wr;
  assign wr_addr = name_idx_r[AW-1:0];
  assign wr_data = b;

  assign result.byte_role    = role;
  assign result.byte_value   = b;
  assign result.entry_end    = end_flag;
  assign result.name_length  = nlen;
  assign result.parse_status = err;
  assign result.payload_end  = last;

  `STP_ASSERT_NEXT(a_last_clears, accept && last,
    phase_r == PH_TYPE && sticky_r == stp_pkg::ST_OK && !have_prev_r,
    "payload end did not clear parse state")
  `STP_ASSERT_NEXT(a_sticky_holds, accept && !last && sticky_r != stp_pkg::ST_OK,
    $stable(sticky_r), "sticky error changed inside payload")
  `STP_ASSERT_NOW(a_write_in_name, wr_en, phase_r == PH_NAME && sticky_r == stp_pkg::ST_OK,
    "name store written outside name field")

endmodule

`default_nettype wire

/* hw/rtl/stp_out_stage.sv */
// result register between the parser and the output channel
// uses stp_pkg and the assertion macro header
`default_nettype none
`include "sorted_tree_record_parser_top_defines.svh"

module stp_out_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    load,
  input  wire stp_pkg::out_item_t result,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output stp_pkg::out_item_t      out_data
);

  logic               out_valid_r;
  stp_pkg::out_item_t out_data_r;

  assign in_ready = !out_valid_r || out_ready;
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `STP_ASSERT_NOW(a_empty_ready, !out_valid_r, in_ready, "empty result register stalls input")
  `STP_ASSERT_NEXT(a_load_valid, load, out_valid_r, "accepted beat produced no result")

endmodule

`default_nettype wire

/* hw/rtl/sorted_tree_record_parser_top.sv */
// result: registered; appears in the cycle after its input beat is accepted
// one byte per cycle unless stalled; the previous-name ram read is fetched
//   one index ahead so the registered read never stalls the name compare
// reset: synchronous, active low; clears parse state, result valid and sets
//   the type codes to 1 and 2; the previous-name ram is not cleared
`default_nettype none

module sorted_tree_record_parser_top #(
  parameter int HASH_BYTES = stp_pkg::HASH_BYTES_DEF,
  parameter int MAX_NAME   = stp_pkg::MAX_NAME_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire stp_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output stp_pkg::out_item_t      out_data,
  input  wire logic               cfg_wr_en,
  input  wire logic [0:0]         cfg_addr,
  input  wire logic [7:0]         cfg_wdata
);

  localparam int AW = stp_pkg::addr_w(MAX_NAME);

  stp_pkg::cfg_regs_t cfg_r;
  stp_pkg::out_item_t result;
  logic               load;
  logic [7:0]         rd_data;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [7:0]         wr_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.blob_type_code <= 8'd1;
      cfg_r.tree_type_code <= 8'd2;
    end else if (cfg_wr_en) begin
      unique case (stp_pkg::cfg_idx_t'(cfg_addr))
        stp_pkg::CFG_BLOB: cfg_r.blob_type_code <= cfg_wdata;
        stp_pkg::CFG_TREE: cfg_r.tree_type_code <= cfg_wdata;
        default: ;
      endcase
    end
  end

  stp_parser #(
    .HASH_BYTES (HASH_BYTES),
    .MAX_NAME   (MAX_NAME)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (load),
    .in_item (in_data),
    .cfg     (cfg_r),
    .rd_data (rd_data),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .result  (result)
  );

  stp_ram #(
    .WIDTH (8),
    .DEPTH (MAX_NAME)
  ) u_name_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  stp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .load      (load),
    .result    (result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
